[sv/cqm_pkg.sv]
`default_nettype none

package cqm_pkg;

    localparam int CQM_MAX_CORNERS = 16;
    localparam int BOX_W = 32;
    localparam int OUT_W = 120;

    localparam logic [19:0] SNAP_CAP = 20'd640000;

    localparam logic [12:0] RATIO_RESET = 13'd339;
    localparam logic [15:0] ANGLE_RESET = 16'd179;
    localparam logic [19:0] DIST_RESET  = 20'd225;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RATIO = 2'd0;
    localparam logic [1:0] CFG_ANGLE = 2'd1;
    localparam logic [1:0] CFG_DIST  = 2'd2;

    // Corner classes.
    localparam logic [1:0] CLS_TL = 2'd0;
    localparam logic [1:0] CLS_TR = 2'd1;
    localparam logic [1:0] CLS_BR = 2'd2;
    localparam logic [1:0] CLS_BL = 2'd3;

    // Datapath operations.
    localparam logic [4:0] OP_IDLE      = 5'd0;
    localparam logic [4:0] OP_CAP_F     = 5'd1;
    localparam logic [4:0] OP_CAP_M     = 5'd2;
    localparam logic [4:0] OP_CAP_L     = 5'd3;
    localparam logic [4:0] OP_DIFF      = 5'd4;
    localparam logic [4:0] OP_L1        = 5'd5;
    localparam logic [4:0] OP_L2        = 5'd6;
    localparam logic [4:0] OP_DOT       = 5'd7;
    localparam logic [4:0] OP_RPROD     = 5'd8;
    localparam logic [4:0] OP_UD2       = 5'd9;
    localparam logic [4:0] OP_L12       = 5'd10;
    localparam logic [4:0] OP_APROD     = 5'd11;
    localparam logic [4:0] OP_SNAP_INIT = 5'd12;
    localparam logic [4:0] OP_SNAP_D    = 5'd13;
    localparam logic [4:0] OP_SNAP_CMP  = 5'd14;
    localparam logic [4:0] OP_QUAD_D    = 5'd15;
    localparam logic [4:0] OP_AREA      = 5'd16;
    localparam logic [4:0] OP_UPDATE    = 5'd17;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] pass;
        logic       wr_en;
        logic       rd_en;
        logic       drop;
        logic       emit;
    } cqm_cmd_t;

    typedef struct packed {
        logic link_fm;
        logic link_ml;
        logic geo_ok;
        logic out_free;
    } cqm_stat_t;

    // Halves a doubled coordinate, rounding a half to the even integer.
    function automatic logic signed [12:0] half_even(input logic [13:0] s);
        logic signed [12:0] fl;
        fl = s[13:1];
        if (s[0] && fl[0])
        begin
            fl = fl + 13'sd1;
        end
        return fl;
    endfunction

    function automatic logic signed [12:0] center_x(input logic [BOX_W-1:0] b);
        return half_even(14'({b[9:0], 1'b0}) + 14'(b[25:20]));
    endfunction

    function automatic logic signed [12:0] center_y(input logic [BOX_W-1:0] b);
        return half_even(14'({b[19:10], 1'b0}) + 14'(b[31:26]));
    endfunction

    // Adjacency of box a (class c) and box b (class c+1).
    function automatic logic linked(input logic [1:0] c, input logic [BOX_W-1:0] a,
                                    input logic [BOX_W-1:0] b);
        logic [10:0] ax, ay, ax2, ay2, cx, cy, cx2, cy2;
        logic        r;
        ax  = 11'(a[9:0]);
        ay  = 11'(a[19:10]);
        ax2 = ax + 11'(a[25:20]);
        ay2 = ay + 11'(a[31:26]);
        cx  = 11'(b[9:0]);
        cy  = 11'(b[19:10]);
        cx2 = cx + 11'(b[25:20]);
        cy2 = cy + 11'(b[31:26]);
        case (c)
            CLS_TL:  r = (ax2 < cx) && (ay2 > cy) && (ay < cy2);
            CLS_TR:  r = (ay2 < cy) && (ax < cx2) && (ax2 > cx);
            CLS_BR:  r = (ax > cx2) && (ay < cy2) && (ay2 > cy);
            default: r = (cy2 < ay) && (cx < ax2) && (cx2 > ax);
        endcase
        return r;
    endfunction

    function automatic logic [11:0] sat12(input logic signed [12:0] v);
        logic [11:0] r;
        if (v < -13'sd1024)
        begin
            r = 12'h400;
        end
        else if (v > 13'sd2047)
        begin
            r = 12'h7FF;
        end
        else
        begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/cqm_ram.sv]
`default_nettype none

module cqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/cqm_dp.sv]
`default_nettype none

module cqm_dp
    import cqm_pkg::*;
#(
    parameter int MAX_CORNERS = CQM_MAX_CORNERS,
    parameter int AW = $clog2(4 * MAX_CORNERS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [19:0]      cfg_wdata,
    input  wire cqm_cmd_t         cmd,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [AW-1:0]    rd_addr,
    input  wire logic [BOX_W-1:0] wr_data,
    output cqm_stat_t             stat,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    logic [12:0] ratio_reg;
    logic [15:0] angle_reg;
    logic [19:0] dist_reg;

    logic [BOX_W-1:0] rd_data;
    logic [BOX_W-1:0] f_box_reg, m_box_reg, l_box_reg;
    logic signed [12:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg, p3x_reg, p3y_reg;
    logic signed [12:0] rcx, rcy;
    logic signed [12:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [12:0] vcx_reg, vcy_reg;
    logic [22:0] l1_reg, l2_reg, ud_reg;
    logic [35:0] rp1_reg, rp2_reg;
    logic [45:0] ud2_reg, l12_reg;
    logic [61:0] aprod_reg;
    logic signed [12:0] cx_reg, cy_reg, snx_reg, sny_reg;
    logic [27:0] d_reg, d1_reg, d2_reg;
    logic [19:0] best_d_reg, lim;
    logic [55:0] area_reg, best_area_reg;
    logic signed [12:0] bqx_reg [4];
    logic signed [12:0] bqy_reg [4];
    logic signed [12:0] qx [4];
    logic signed [12:0] qy [4];
    logic [14:0] total_reg;
    logic        ovf_reg;
    logic        out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic signed [23:0] dot;
    logic signed [13:0] sdx, sdy, q02x, q02y, q13x, q13y;
    logic [13:0] vsx, vsy;

    cqm_ram #(
        .WIDTH(BOX_W),
        .DEPTH(4 * MAX_CORNERS)
    ) u_store (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign rcx = center_x(rd_data);
    assign rcy = center_y(rd_data);
    assign lim = (dist_reg < SNAP_CAP) ? dist_reg : SNAP_CAP;

    assign dot = 24'(dx1_reg) * 24'(dx2_reg) + 24'(dy1_reg) * 24'(dy2_reg);

    // Doubled centre of the virtual corner: origin f + l - m, with m's size.
    assign vsx = 14'({f_box_reg[9:0], 1'b0}) + 14'({l_box_reg[9:0], 1'b0})
               - 14'({m_box_reg[9:0], 1'b0}) + 14'(m_box_reg[25:20]);
    assign vsy = 14'({f_box_reg[19:10], 1'b0}) + 14'({l_box_reg[19:10], 1'b0})
               - 14'({m_box_reg[19:10], 1'b0}) + 14'(m_box_reg[31:26]);

    // Distance is taken from the candidate that the store presents this cycle.
    assign sdx = 14'(vcx_reg) - 14'(rcx);
    assign sdy = 14'(vcy_reg) - 14'(rcy);

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            case (2'(c) - cmd.pass)
                2'd0:
                begin
                    qx[c] = p1x_reg;
                    qy[c] = p1y_reg;
                end
                2'd1:
                begin
                    qx[c] = p2x_reg;
                    qy[c] = p2y_reg;
                end
                2'd2:
                begin
                    qx[c] = p3x_reg;
                    qy[c] = p3y_reg;
                end
                default:
                begin
                    qx[c] = snx_reg;
                    qy[c] = sny_reg;
                end
            endcase
        end
    end

    assign q02x = 14'(qx[0]) - 14'(qx[2]);
    assign q02y = 14'(qy[0]) - 14'(qy[2]);
    assign q13x = 14'(qx[1]) - 14'(qx[3]);
    assign q13y = 14'(qy[1]) - 14'(qy[3]);

    assign stat.link_fm  = linked(cmd.pass, f_box_reg, rd_data);
    assign stat.link_ml  = linked(cmd.pass + 2'd1, m_box_reg, rd_data);
    assign stat.geo_ok   = (36'({l1_reg, 8'b0}) < rp2_reg) && (36'({l2_reg, 8'b0}) < rp1_reg)
                         && ({ud2_reg, 16'b0} < aprod_reg);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Working registers of the search.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAP_F:
            begin
                f_box_reg <= rd_data;
                p1x_reg   <= rcx;
                p1y_reg   <= rcy;
            end
            OP_CAP_M:
            begin
                m_box_reg <= rd_data;
                p2x_reg   <= rcx;
                p2y_reg   <= rcy;
            end
            OP_CAP_L:
            begin
                l_box_reg <= rd_data;
                p3x_reg   <= rcx;
                p3y_reg   <= rcy;
            end
            OP_DIFF:
            begin
                dx1_reg <= p1x_reg - p2x_reg;
                dy1_reg <= p1y_reg - p2y_reg;
                dx2_reg <= p3x_reg - p2x_reg;
                dy2_reg <= p3y_reg - p2y_reg;
                vcx_reg <= half_even(vsx);
                vcy_reg <= half_even(vsy);
            end
            OP_L1:
            begin
                l1_reg <= 23'(26'(dx1_reg) * 26'(dx1_reg) + 26'(dy1_reg) * 26'(dy1_reg));
            end
            OP_L2:
            begin
                l2_reg <= 23'(26'(dx2_reg) * 26'(dx2_reg) + 26'(dy2_reg) * 26'(dy2_reg));
            end
            OP_DOT:
            begin
                ud_reg <= (dot < 0) ? 23'(-dot) : 23'(dot);
            end
            OP_RPROD:
            begin
                rp1_reg <= 36'(ratio_reg) * 36'(l1_reg);
                rp2_reg <= 36'(ratio_reg) * 36'(l2_reg);
            end
            OP_UD2:
            begin
                ud2_reg <= 46'(ud_reg) * 46'(ud_reg);
            end
            OP_L12:
            begin
                l12_reg <= 46'(l1_reg) * 46'(l2_reg);
            end
            OP_APROD:
            begin
                aprod_reg <= 62'(angle_reg) * 62'(l12_reg);
            end
            OP_SNAP_INIT:
            begin
                snx_reg    <= vcx_reg;
                sny_reg    <= vcy_reg;
                best_d_reg <= SNAP_CAP;
            end
            OP_SNAP_D:
            begin
                cx_reg <= rcx;
                cy_reg <= rcy;
                d_reg  <= 28'(sdx) * 28'(sdx) + 28'(sdy) * 28'(sdy);
            end
            OP_SNAP_CMP:
            begin
                if (d_reg < 28'(lim) && d_reg < 28'(best_d_reg))
                begin
                    snx_reg    <= cx_reg;
                    sny_reg    <= cy_reg;
                    best_d_reg <= d_reg[19:0];
                end
            end
            OP_QUAD_D:
            begin
                d1_reg <= 28'(q02x) * 28'(q02x) + 28'(q02y) * 28'(q02y);
                d2_reg <= 28'(q13x) * 28'(q13x) + 28'(q13y) * 28'(q13y);
            end
            OP_AREA:
            begin
                area_reg <= 56'(d1_reg) * 56'(d2_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            angle_reg     <= ANGLE_RESET;
            dist_reg      <= DIST_RESET;
            best_area_reg <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                bqx_reg[c] <= '0;
                bqy_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RATIO: ratio_reg <= cfg_wdata[12:0];
                    CFG_ANGLE: angle_reg <= cfg_wdata[15:0];
                    CFG_DIST:  dist_reg  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.drop)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.op == OP_UPDATE)
            begin
                if (total_reg != 15'h7FFF)
                begin
                    total_reg <= total_reg + 15'd1;
                end
                if (area_reg > best_area_reg)
                begin
                    best_area_reg <= area_reg;
                    for (int c = 0; c < 4; c++)
                    begin
                        bqx_reg[c] <= qx[c];
                        bqy_reg[c] <= qy[c];
                    end
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                best_area_reg <= '0;
                total_reg     <= '0;
                ovf_reg       <= 1'b0;
                for (int c = 0; c < 4; c++)
                begin
                    bqx_reg[c] <= '0;
                    bqy_reg[c] <= '0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {7'b0, ovf_reg, total_reg,
                             sat12(bqy_reg[3]), sat12(bqx_reg[3]),
                             sat12(bqy_reg[2]), sat12(bqx_reg[2]),
                             sat12(bqy_reg[1]), sat12(bqx_reg[1]),
                             sat12(bqy_reg[0]), sat12(bqx_reg[0]),
                             (total_reg != 15'd0)};
        end
    end

endmodule

`default_nettype wire

[sv/cqm_ctrl.sv]
`default_nettype none

module cqm_ctrl
    import cqm_pkg::*;
#(
    parameter int MAX_CORNERS = CQM_MAX_CORNERS,
    parameter int AW = $clog2(4 * MAX_CORNERS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [2:0]    s_tuser,
    input  wire logic          s_tlast,
    input  wire cqm_stat_t     stat,
    output cqm_cmd_t           cmd,
    output logic [AW-1:0]      wr_addr,
    output logic [AW-1:0]      rd_addr
);

    localparam int CW = $clog2(MAX_CORNERS + 1);

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_I        = 5'd1;
    localparam logic [4:0] S_I_CAP    = 5'd2;
    localparam logic [4:0] S_J        = 5'd3;
    localparam logic [4:0] S_J_CAP    = 5'd4;
    localparam logic [4:0] S_K        = 5'd5;
    localparam logic [4:0] S_K_CAP    = 5'd6;
    localparam logic [4:0] S_DIFF     = 5'd7;
    localparam logic [4:0] S_L1       = 5'd8;
    localparam logic [4:0] S_L2       = 5'd9;
    localparam logic [4:0] S_DOT      = 5'd10;
    localparam logic [4:0] S_RPROD    = 5'd11;
    localparam logic [4:0] S_UD2      = 5'd12;
    localparam logic [4:0] S_L12      = 5'd13;
    localparam logic [4:0] S_APROD    = 5'd14;
    localparam logic [4:0] S_TEST     = 5'd15;
    localparam logic [4:0] S_SNAP     = 5'd16;
    localparam logic [4:0] S_SNAP_CAP = 5'd17;
    localparam logic [4:0] S_SNAP_CMP = 5'd18;
    localparam logic [4:0] S_QUAD     = 5'd19;
    localparam logic [4:0] S_AREA     = 5'd20;
    localparam logic [4:0] S_UPDATE   = 5'd21;
    localparam logic [4:0] S_EMIT     = 5'd22;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CORNERS);

    logic [4:0]    state_reg, state_next;
    logic [1:0]    p_reg, p_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, n_reg, n_next;
    logic [CW-1:0] cnt_reg [4];
    logic [CW-1:0] cnt_next [4];
    logic [1:0]    cf, cm, cl, cq, in_cls;

    function automatic logic [AW-1:0] addr_of(input logic [1:0] c, input logic [CW-1:0] idx);
        return AW'(c) * AW'(MAX_CORNERS) + AW'(idx);
    endfunction

    assign cf = p_reg;
    assign cm = p_reg + 2'd1;
    assign cl = p_reg + 2'd2;
    assign cq = p_reg + 2'd3;
    assign in_cls = s_tuser[1:0];

    assign s_tready = (state_reg == S_LOAD);
    assign wr_addr  = addr_of(in_cls, cnt_reg[in_cls]);

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        for (int c = 0; c < 4; c++)
        begin
            cnt_next[c] = cnt_reg[c];
        end
        cmd        = '0;
        cmd.op     = OP_IDLE;
        cmd.pass   = p_reg;
        rd_addr    = addr_of(cf, i_reg);

        case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[2])
                    begin
                        if (cnt_reg[in_cls] < CNT_MAX)
                        begin
                            cmd.wr_en        = 1'b1;
                            cnt_next[in_cls] = cnt_reg[in_cls] + 1'b1;
                        end
                        else
                        begin
                            cmd.drop = 1'b1;
                        end
                    end
                    if (s_tlast)
                    begin
                        p_next     = 2'd0;
                        i_next     = '0;
                        state_next = S_I;
                    end
                end
            end
            S_I:
            begin
                if (i_reg < cnt_reg[cf])
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_I_CAP;
                end
                else if (p_reg == 2'd3)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    p_next = p_reg + 2'd1;
                    i_next = '0;
                end
            end
            S_I_CAP:
            begin
                cmd.op     = OP_CAP_F;
                j_next     = '0;
                state_next = S_J;
            end
            S_J:
            begin
                rd_addr = addr_of(cm, j_reg);
                if (j_reg < cnt_reg[cm])
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_J_CAP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_I;
                end
            end
            S_J_CAP:
            begin
                cmd.op = OP_CAP_M;
                if (stat.link_fm)
                begin
                    k_next     = '0;
                    state_next = S_K;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_J;
                end
            end
            S_K:
            begin
                rd_addr = addr_of(cl, k_reg);
                if (k_reg < cnt_reg[cl])
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_K_CAP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_J;
                end
            end
            S_K_CAP:
            begin
                cmd.op = OP_CAP_L;
                if (stat.link_ml)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_K;
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_L1;
            end
            S_L1:
            begin
                cmd.op     = OP_L1;
                state_next = S_L2;
            end
            S_L2:
            begin
                cmd.op     = OP_L2;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                cmd.op     = OP_DOT;
                state_next = S_RPROD;
            end
            S_RPROD:
            begin
                cmd.op     = OP_RPROD;
                state_next = S_UD2;
            end
            S_UD2:
            begin
                cmd.op     = OP_UD2;
                state_next = S_L12;
            end
            S_L12:
            begin
                cmd.op     = OP_L12;
                state_next = S_APROD;
            end
            S_APROD:
            begin
                cmd.op     = OP_APROD;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (stat.geo_ok)
                begin
                    cmd.op     = OP_SNAP_INIT;
                    n_next     = '0;
                    state_next = S_SNAP;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_K;
                end
            end
            S_SNAP:
            begin
                rd_addr = addr_of(cq, n_reg);
                if (n_reg < cnt_reg[cq])
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SNAP_CAP;
                end
                else
                begin
                    state_next = S_QUAD;
                end
            end
            S_SNAP_CAP:
            begin
                cmd.op     = OP_SNAP_D;
                state_next = S_SNAP_CMP;
            end
            S_SNAP_CMP:
            begin
                cmd.op     = OP_SNAP_CMP;
                n_next     = n_reg + 1'b1;
                state_next = S_SNAP;
            end
            S_QUAD:
            begin
                cmd.op     = OP_QUAD_D;
                state_next = S_AREA;
            end
            S_AREA:
            begin
                cmd.op     = OP_AREA;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                k_next     = k_reg + 1'b1;
                state_next = S_K;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    for (int c = 0; c < 4; c++)
                    begin
                        cnt_next[c] = '0;
                    end
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            p_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            for (int c = 0; c < 4; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            for (int c = 0; c < 4; c++)
            begin
                cnt_reg[c] <= cnt_next[c];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_MAX && cnt_reg[1] <= CNT_MAX &&
        cnt_reg[2] <= CNT_MAX && cnt_reg[3] <= CNT_MAX)
        else $error("class count above store depth");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (cnt_reg[0] == '0 && cnt_reg[1] == '0 &&
                      cnt_reg[2] == '0 && cnt_reg[3] == '0 && state_reg == S_LOAD))
        else $error("counts not cleared after result");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("store written and read in one cycle");

endmodule

`default_nettype wire

[sv/corner_quad_matcher_core.sv]
// Corner quad matcher.
// Input items arrive on s_t*: one corner box per item (class and store flag in
// s_tuser, box geometry in s_tdata); s_tlast marks the last item of a frame.
// Box items are taken one per cycle. The frame's last item starts a search over
// all stored boxes; no input item is taken until its result has been placed in
// the output register. The search runs on one store read port and one chain of
// registered arithmetic: in each of four passes, every adjacent (f,m) pair is
// tried with every l box, each adjacent triple gets the ratio and angle tests
// and, if it passes, a snap search. One result item per frame leaves on m_t*,
// held until m_tready; the next frame loads while it waits, and a later result
// waits for the output to drain. cfg_we/cfg_addr/cfg_wdata write the three
// limits; the user must write them only while idle; the block has no check.
// Reset clears all counts, the best quad, the overflow flag and the output,
// and loads the limit registers with their defaults; the box store needs no
// clearing since only entries below each class count are read.
`default_nettype none

module corner_quad_matcher_core
    import cqm_pkg::*;
#(
    parameter int MAX_CORNERS = CQM_MAX_CORNERS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [19:0]      cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // box_left, box_top, box_width, box_height
    input  wire logic [BOX_W-1:0] s_tdata,
    // corner_class, has_corner
    input  wire logic [2:0]       s_tuser,
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // found, tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y, quad_count,
    // store_overflow, zero fill
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW = $clog2(4 * MAX_CORNERS);

    cqm_cmd_t      cmd;
    cqm_stat_t     stat;
    logic [AW-1:0] wr_addr, rd_addr;

    cqm_ctrl #(
        .MAX_CORNERS(MAX_CORNERS),
        .AW         (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .stat    (stat),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    cqm_dp #(
        .MAX_CORNERS(MAX_CORNERS),
        .AW         (AW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .wr_data  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
